// ===== rtl/core/fba_pkg.sv =====
// Shared types and constants of the frame bitmap allocator.
// Used by fba_ctrl, fba_dp and frame_bitmap_allocator; depends on nothing.
`default_nettype none

package fba_pkg;

  localparam int NUM_FRAMES   = 65536;
  localparam int STORE_WORDS  = (NUM_FRAMES + 31) / 32;
  localparam int WADDR_W      = $clog2(STORE_WORDS);
  localparam int FRAME_W      = WADDR_W + 5;
  localparam int REG_W        = 17;
  localparam int FRAME_SHIFT  = 12;
  localparam int CFG_IDX_W    = 1;

  localparam logic [1:0] FUNC_ALLOC     = 2'd0;
  localparam logic [1:0] FUNC_FREE      = 2'd1;
  localparam logic [1:0] FUNC_MARK_USED = 2'd2;
  localparam logic [1:0] FUNC_MARK_FREE = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_HINT  = 1'd1;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] addr;
    logic [31:0] end_addr;
  } in_item_t;

  typedef struct packed {
    logic [31:0] frame_addr;
    logic        found;
  } out_item_t;

  typedef struct packed {
    logic clr;
    logic capture;
    logic setup;
    logic rd;
    logic chk;
    logic step;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic empty;
    logic last;
    logic hit;
    logic is_alloc;
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/fba_dp.sv =====
// Datapath of the frame bitmap allocator: bitmap memory, word walker, result register.
// Depends on fba_pkg; driven by fba_ctrl through dp_cmd_t and reporting through dp_sts_t.
`default_nettype none

module fba_dp
  import fba_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [REG_W-1:0]     cfg_wdata,
  input  in_item_t             in_data,
  input  dp_cmd_t              cmd,
  output dp_sts_t              sts,
  output out_item_t            out_data
);

  logic [31:0]        mem [STORE_WORDS];
  logic [31:0]        rd_data_r;
  logic [WADDR_W-1:0] w_r;
  logic [REG_W-1:0]   frame_count_r;
  logic [REG_W-1:0]   start_hint_r;
  in_item_t           item_r;
  logic [REG_W-1:0]   lo_r;
  logic [REG_W-1:0]   hi_r;
  logic               empty_r;
  logic               alloc_r;
  logic               set_r;
  logic               res_found_r;
  logic [FRAME_W-1:0] res_idx_r;
  out_item_t          out_data_r;

  logic [REG_W-1:0]   eff;
  logic [20:0]        lo_s;
  logic [20:0]        hic_s;
  logic [20:0]        hi_s;
  logic [32:0]        end_sum;
  logic               empty_s;
  logic [REG_W-1:0]   hi_m1;
  logic [WADDR_W-1:0] last_w;
  logic [31:0]        lo_mask;
  logic [31:0]        hi_mask;
  logic [31:0]        mask;
  logic [31:0]        cand;
  logic               hit;
  logic [4:0]         bit_idx;
  logic [31:0]        wr_word;
  logic               mem_we;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_count_r <= '0;
      start_hint_r  <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx)
        CFG_FRAME_COUNT: frame_count_r <= cfg_wdata;
        CFG_START_HINT:  start_hint_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    eff     = (frame_count_r > REG_W'(NUM_FRAMES)) ? REG_W'(NUM_FRAMES) : frame_count_r;
    end_sum = {1'b0, item_r.end_addr} + 33'd4095;
    lo_s    = {1'b0, item_r.addr[31:FRAME_SHIFT]};
    empty_s = 1'b0;
    case (item_r.func)
      FUNC_ALLOC: begin
        lo_s  = 21'(start_hint_r);
        hic_s = 21'(eff);
      end
      FUNC_FREE: begin
        hic_s   = lo_s + 21'd1;
        empty_s = (item_r.addr == 32'd0);
      end
      default: hic_s = end_sum[32:FRAME_SHIFT];
    endcase
    hi_s = (hic_s < 21'(eff)) ? hic_s : 21'(eff);
    if (lo_s >= hi_s) begin
      empty_s = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_data;
    end
    if (cmd.setup) begin
      lo_r    <= lo_s[REG_W-1:0];
      hi_r    <= hi_s[REG_W-1:0];
      empty_r <= empty_s;
      alloc_r <= (item_r.func == FUNC_ALLOC);
      set_r   <= (item_r.func == FUNC_MARK_USED);
    end
  end

  always_comb begin
    hi_m1   = hi_r - REG_W'(1);
    last_w  = hi_m1[5 +: WADDR_W];
    lo_mask = (w_r == lo_r[5 +: WADDR_W]) ? ({32{1'b1}} << lo_r[4:0]) : {32{1'b1}};
    hi_mask = (w_r == last_w && hi_r[4:0] != 5'd0) ? ~({32{1'b1}} << hi_r[4:0])
                                                    : {32{1'b1}};
    mask    = lo_mask & hi_mask;
    cand    = ~rd_data_r & mask;
    hit     = |cand;
    bit_idx = '0;
    for (int i = 31; i >= 0; i--) begin
      if (cand[i]) begin
        bit_idx = 5'(i);
      end
    end
    if (alloc_r) begin
      wr_word = rd_data_r | (32'd1 << bit_idx);
    end else if (set_r) begin
      wr_word = rd_data_r | mask;
    end else begin
      wr_word = rd_data_r & ~mask;
    end
    mem_we = cmd.chk && (!alloc_r || hit);
  end

  always_ff @(posedge clk) begin
    if (cmd.clr) begin
      mem[w_r] <= {32{1'b1}};
    end else if (mem_we) begin
      mem[w_r] <= wr_word;
    end
    if (cmd.rd) begin
      rd_data_r <= mem[w_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r <= '0;
    end else if (cmd.setup) begin
      w_r <= lo_s[5 +: WADDR_W];
    end else if (cmd.step || cmd.clr) begin
      w_r <= w_r + WADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      res_found_r <= 1'b0;
      res_idx_r   <= '0;
    end else if (cmd.chk && alloc_r && hit) begin
      res_found_r <= 1'b1;
      res_idx_r   <= {w_r, bit_idx};
    end
    if (cmd.emit) begin
      out_data_r.found      <= res_found_r;
      out_data_r.frame_addr <= 32'({res_idx_r, {FRAME_SHIFT{1'b0}}});
    end
  end

  assign sts.clr_last = (w_r == WADDR_W'(STORE_WORDS - 1));
  assign sts.empty    = empty_r;
  assign sts.last     = (w_r == last_w);
  assign sts.hit      = hit;
  assign sts.is_alloc = alloc_r;
  assign out_data     = out_data_r;

  a_alloc_sets_one_bit: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.chk && alloc_r && hit) |-> $onehot(wr_word ^ rd_data_r))
    else $error("allocation changed other than one bit");

  a_walk_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.chk |-> (w_r <= last_w && w_r >= lo_r[5 +: WADDR_W]))
    else $error("word walker left the frame window");

  a_found_only_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && !alloc_r) |=> !out_data_r.found)
    else $error("found flag set for a non-allocate transfer");

endmodule

`default_nettype wire

// ===== rtl/core/fba_ctrl.sv =====
// Controller of the frame bitmap allocator: clearing pass, per-item sequencing, result valid.
// Depends on fba_pkg; commands fba_dp through dp_cmd_t and reads its dp_sts_t.
`default_nettype none

module fba_ctrl
  import fba_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETUP,
    ST_START,
    ST_RD,
    ST_CHK,
    ST_DONE
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   slot_free;

  always_comb begin
    slot_free     = !out_valid_r || !out_stall;
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = ST_START;
      end
      ST_START: begin
        state_nxt = sts.empty ? ST_DONE : ST_RD;
      end
      ST_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_CHK;
      end
      ST_CHK: begin
        cmd.chk = 1'b1;
        if ((sts.is_alloc && sts.hit) || sts.last) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.step  = 1'b1;
          state_nxt = ST_RD;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  a_chk_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CHK) |-> ($past(state_r) == ST_RD))
    else $error("word check without a preceding read");

  a_valid_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_DONE))
    else $error("result raised outside completion");

  a_emit_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !(out_valid_r && out_stall))
    else $error("result register overwritten while stalled");

endmodule

`default_nettype wire

// ===== rtl/core/frame_bitmap_allocator.sv =====
// First-fit bitmap allocator of 4 KiB physical frames, one used bit per frame.
// After reset the bitmap memory is swept to all used, one word per cycle over all
// 2048 words, during which no item is taken (configuration writes still are).
// Each item is then captured and set up, and each 32-frame bitmap word it visits is
// read from the single-port bitmap memory and then checked, with any update written
// back, before the result is emitted: an allocate walks words from the start hint up
// to the first free frame, and a region or free walks every word the clipped range touches.
// Depends on fba_pkg, fba_ctrl and fba_dp.
`default_nettype none

module frame_bitmap_allocator
  import fba_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [REG_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  fba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  fba_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== bench/tb_frame_bitmap_allocator.sv =====
// Self-checking testbench of frame_bitmap_allocator: directed corner cases, then random
// phases of allocate, free and region requests, checked against a bitmap mirror.
// Depends on fba_pkg and frame_bitmap_allocator.
module tb_frame_bitmap_allocator import fba_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IDLE_LIMIT = 40000;
  localparam int unsigned PHASES = 13;
  localparam int unsigned PHASE_ITEMS = 104;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [REG_W-1:0] cfg_wdata = '0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  in_item_t         in_data = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_item_t        out_data;

  class frame_ledger;
    logic [31:0]      used_words [STORE_WORDS];
    logic [REG_W-1:0] count_reg;
    logic [REG_W-1:0] hint_reg;
    out_item_t        due_results[$];
    int unsigned      handed_out[$];
    int unsigned      errors;

    function new();
      foreach (used_words[w]) used_words[w] = '1;
      count_reg = '0;
      hint_reg = '0;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] val);
      if (idx == CFG_FRAME_COUNT) count_reg = val;
      else if (idx == CFG_START_HINT) hint_reg = val;
    endfunction

    function int unsigned live_frames();
      return (count_reg < NUM_FRAMES) ? count_reg : NUM_FRAMES;
    endfunction

    function void put_frame(int unsigned f, bit used);
      used_words[f >> 5][f & 31] = used;
    endfunction

    // Whole words that are fully used are skipped when the scan is word aligned.
    function bit lowest_free(output int unsigned idx);
      int unsigned lim;
      int unsigned f;
      lim = live_frames();
      f = hint_reg;
      idx = 0;
      while (f < lim) begin
        if ((f & 31) == 0 && used_words[f >> 5] == 32'hFFFF_FFFF) f += 32;
        else if (used_words[f >> 5][f & 31] == 1'b0) begin
          idx = f;
          return 1'b1;
        end else f++;
      end
      return 1'b0;
    endfunction

    function void paint_range(logic [31:0] a, logic [31:0] e, bit used);
      longint unsigned lo;
      longint unsigned hi;
      longint unsigned f;
      lo = 64'(a) >> FRAME_SHIFT;
      hi = (64'(e) + 64'd4095) >> FRAME_SHIFT;
      if (hi > live_frames()) hi = live_frames();
      for (f = lo; f < hi; f++) put_frame(32'(f), used);
    endfunction

    function void take_request(in_item_t req);
      out_item_t   r;
      int unsigned f;
      r = '0;
      case (req.func)
        FUNC_ALLOC: begin
          if (lowest_free(f)) begin
            put_frame(f, 1'b1);
            r.frame_addr = 32'(f) << FRAME_SHIFT;
            r.found = 1'b1;
            handed_out.push_back(f);
          end
        end
        FUNC_FREE: begin
          if (req.addr != 0 && (req.addr >> FRAME_SHIFT) < live_frames())
            put_frame(req.addr >> FRAME_SHIFT, 1'b0);
        end
        FUNC_MARK_USED: paint_range(req.addr, req.end_addr, 1'b1);
        default: paint_range(req.addr, req.end_addr, 1'b0);
      endcase
      due_results.push_back(r);
    endfunction

    function void match_result(out_item_t got);
      out_item_t want;
      if (due_results.size() == 0) begin
        errors++;
        $display("%0t: result with none expected, frame_addr %h found %b",
                 $time, got.frame_addr, got.found);
        return;
      end
      want = due_results.pop_front();
      if (got.frame_addr !== want.frame_addr) begin
        errors++;
        $display("%0t: frame_addr expected %h actual %h", $time, want.frame_addr,
                 got.frame_addr);
      end
      if (got.found !== want.found) begin
        errors++;
        $display("%0t: found expected %b actual %b", $time, want.found, got.found);
      end
    endfunction
  endclass

  frame_ledger ledger = new();

  frame_bitmap_allocator DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) ledger.take_request(in_data);
      if (out_valid && !out_stall) ledger.match_result(out_data);
    end
  end

  int unsigned rx_left = 0;
  bit          rx_hold = 1'b0;

  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_hold = ($urandom_range(0, 2) == 0);
      rx_left = rx_hold ? $urandom_range(1, 7) : $urandom_range(1, 60);
    end
    rx_left--;
    out_stall <= rx_hold;
  end

  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("[frame_bitmap_allocator] ERROR");
      $finish;
    end
  end

  function automatic in_item_t req(logic [1:0] fn, logic [31:0] a, logic [31:0] e);
    in_item_t it;
    it.func = fn;
    it.addr = a;
    it.end_addr = e;
    return it;
  endfunction

  // Mostly allocations, frees of handed-out frames and short regions near base,
  // with a share of fully random requests.
  function automatic in_item_t make_request(int unsigned base);
    in_item_t    it;
    int unsigned pick;
    int unsigned sf;
    int unsigned nf;
    int unsigned k;
    it.func = FUNC_ALLOC;
    it.addr = $urandom;
    it.end_addr = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      it.func = FUNC_ALLOC;
    end else if (pick < 62) begin
      it.func = FUNC_FREE;
      if (ledger.handed_out.size() != 0) begin
        k = $urandom_range(0, ledger.handed_out.size() - 1);
        it.addr = (ledger.handed_out[k] << FRAME_SHIFT) | $urandom_range(0, 4095);
        ledger.handed_out.delete(k);
      end
    end else if (pick < 92) begin
      it.func = (pick < 77) ? FUNC_MARK_USED : FUNC_MARK_FREE;
      sf = base + $urandom_range(0, 255);
      nf = $urandom_range(0, 48);
      it.addr = (sf << FRAME_SHIFT) | $urandom_range(0, 4095);
      it.end_addr = ((sf + nf) << FRAME_SHIFT);
      if ($urandom_range(0, 3) != 0) it.end_addr[11:0] = 12'($urandom_range(0, 4095));
    end else begin
      it.func = 2'($urandom_range(0, 3));
    end
    return it;
  endfunction

  task automatic push_request(in_item_t it);
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (ledger.due_results.size() != 0) @(posedge clk);
  endtask

  task automatic program_regs(logic [REG_W-1:0] cnt, logic [REG_W-1:0] hint);
    cfg_wr_en <= 1'b1;
    cfg_idx <= CFG_FRAME_COUNT;
    cfg_wdata <= cnt;
    @(posedge clk);
    cfg_idx <= CFG_START_HINT;
    cfg_wdata <= hint;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    ledger.set_reg(CFG_FRAME_COUNT, cnt);
    ledger.set_reg(CFG_START_HINT, hint);
  endtask

  initial begin
    logic [REG_W-1:0] ph_count;
    logic [REG_W-1:0] ph_hint;
    int unsigned      base;
    int unsigned      gap_max;
    int unsigned      gap;
    int unsigned      burst_left;
    burst_left = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    program_regs(17'd0, 17'd0);
    push_request(req(FUNC_ALLOC, 32'h0, 32'h0));
    drain();
    program_regs(17'd64, 17'd0);
    push_request(req(FUNC_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    push_request(req(FUNC_MARK_FREE, 32'h0, 32'h0004_0000));
    push_request(req(FUNC_ALLOC, 32'h0, 32'h0));
    push_request(req(FUNC_ALLOC, 32'h0, 32'h0));
    push_request(req(FUNC_FREE, 32'h0, 32'hFFFF_FFFF));
    push_request(req(FUNC_FREE, 32'h0000_1000, 32'h0));
    push_request(req(FUNC_ALLOC, 32'h0, 32'h0));
    push_request(req(FUNC_FREE, 32'hFFFF_FFFF, 32'h0));
    push_request(req(FUNC_MARK_USED, 32'hFFFF_F000, 32'hFFFF_FFFF));
    push_request(req(FUNC_MARK_USED, 32'h0002_0000, 32'h0001_0000));
    push_request(req(FUNC_MARK_USED, 32'h0000_1FFF, 32'h0000_2001));
    push_request(req(FUNC_MARK_FREE, 32'h0, 32'hFFFF_FFFF));
    push_request(req(FUNC_ALLOC, 32'h0, 32'h0));
    push_request(req(FUNC_MARK_USED, 32'h0000_3000, 32'h0000_3000));
    push_request(req(FUNC_FREE, 32'h0003_F123, 32'h0));
    drain();
    program_regs(17'h1FFFF, 17'd65504);
    push_request(req(FUNC_MARK_FREE, 32'h0FFE_0000, 32'hFFFF_FFFF));
    push_request(req(FUNC_ALLOC, 32'h0, 32'h0));
    push_request(req(FUNC_FREE, 32'hFFFF_F000, 32'h0));
    push_request(req(FUNC_FREE, 32'h0FFF_F000, 32'h0));
    drain();
    program_regs(17'h10000, 17'h1FFFF);
    push_request(req(FUNC_ALLOC, 32'h0, 32'h0));
    drain();
    program_regs(17'h10000, 17'd0);
    push_request(req(FUNC_MARK_USED, 32'h0, 32'hFFFF_FFFF));
    push_request(req(FUNC_ALLOC, 32'h0, 32'h0));
    push_request(req(FUNC_MARK_FREE, 32'h0, 32'hFFFF_FFFF));
    push_request(req(FUNC_ALLOC, 32'h0, 32'h0));

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      case (ph)
        3: begin
          ph_count = 17'd0;
          ph_hint = 17'($urandom_range(0, 64));
        end
        6: begin
          ph_count = 17'h1FFFF;
          ph_hint = 17'($urandom_range(57344, 65535));
        end
        9: begin
          ph_count = 17'h10000;
          ph_hint = 17'd65535;
        end
        11: begin
          ph_count = 17'($urandom_range(32, 2048));
          ph_hint = 17'h1FFFF;
        end
        default: begin
          ph_count = 17'($urandom_range(32, 2048));
          if ($urandom_range(0, 3) == 0) ph_hint = 17'($urandom_range(0, ph_count - 1));
          else ph_hint = 17'($urandom_range(0, 40));
        end
      endcase
      program_regs(ph_count, ph_hint);
      base = (ph_hint > 128 && ph_hint < 65536) ? ph_hint - 128 : 0;
      gap_max = (ph % 4 == 0) ? 0 : 10;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (burst_left == 0) begin
          gap = $urandom_range(0, gap_max);
          if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
          end
          burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        push_request(make_request(base));
        if (n == PHASE_ITEMS / 2 && ph % 3 == 1) drain();
      end
    end

    drain();
    repeat (16) @(posedge clk);
    if (ledger.errors == 0 && ledger.due_results.size() == 0)
      $display("[frame_bitmap_allocator] OK");
    else
      $display("[frame_bitmap_allocator] ERROR");
    $finish;
  end

endmodule
